// ===== src/hjbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjbd_pkg
// Types and constants of the headset jack and button detector.
// ----------------------------------------------------------------------------
package hjbd_pkg;

    localparam int UV_W  = 21;
    localparam int IDX_W = 3;

    typedef logic [UV_W-1:0] uv_t;

    typedef enum logic [1:0] {
        EV_JACK    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        JACK_EMPTY = 2'd0,
        JACK_MIC   = 2'd1,
        JACK_HP    = 2'd2
    } jack_kind_t;

    typedef enum logic [1:0] {
        KEY_PLAY    = 2'd0,
        KEY_VOLUP   = 2'd1,
        KEY_VOLDOWN = 2'd2
    } key_id_t;

    localparam logic [IDX_W-1:0] REG_MEDIA_MIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MEDIA_MAX   = 3'd1;
    localparam logic [IDX_W-1:0] REG_VOLUP_MIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_VOLUP_MAX   = 3'd3;
    localparam logic [IDX_W-1:0] REG_VOLDOWN_MIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_VOLDOWN_MAX = 3'd5;

    localparam uv_t RST_MEDIA_MIN   = 21'd0;
    localparam uv_t RST_MEDIA_MAX   = 21'd150000;
    localparam uv_t RST_VOLUP_MIN   = 21'd150000;
    localparam uv_t RST_VOLUP_MAX   = 21'd400000;
    localparam uv_t RST_VOLDOWN_MIN = 21'd400000;
    localparam uv_t RST_VOLDOWN_MAX = 21'd600000;

    typedef struct packed {
        logic        valid;
        event_kind_t event_kind;
        jack_kind_t  jack_kind;
        logic        headphone_present;
        logic        mic_present;
        logic        mic_reported;
        key_id_t     key_id;
        logic        key_down;
    } result_t;

endpackage

// ===== src/headset_jack_and_button_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// headset_jack_and_button_detector
// Usage:
//   The input channel (in_valid / in_stall) takes one pin-change item per
//   cycle while in_stall is low: mode, detect_level, key_level, adc_uv and
//   adc_ok. Jack items track insertion and removal and tell a 4-pole headset
//   from a 3-pole headphone; key items decode the button voltage against
//   three programmable ranges. The output channel (out_valid / out_stall)
//   gives at most one result item for each input item; items that cause no
//   result are absorbed silently. An accepted item passes through one input
//   register, then one compare stage into the result register. Throughput is
//   one item per cycle while no result is stalled, set by the single compare
//   stage that also updates jack state. While out_stall holds a result, one
//   more item waits in the input register and in_stall rises only when that
//   register is also full. The range registers are written through cfg_we /
//   cfg_index / cfg_data; indexes above five are ignored.
//   Reset clears the jack state and key marks, empties both registers and
//   loads the default ranges.
// ----------------------------------------------------------------------------
module headset_jack_and_button_detector
    import hjbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             mode,
    input  logic             detect_level,
    input  logic             key_level,
    input  logic [UV_W-1:0]  adc_uv,
    input  logic             adc_ok,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       event_kind,
    output logic [1:0]       jack_kind,
    output logic             headphone_present,
    output logic             mic_present,
    output logic             mic_reported,
    output logic [1:0]       key_id,
    output logic             key_down,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [UV_W-1:0]  cfg_data
);

    uv_t        media_min_reg, media_max_reg;
    uv_t        volup_min_reg, volup_max_reg;
    uv_t        voldown_min_reg, voldown_max_reg;

    logic       s1_valid_reg;
    logic       s1_mode_reg, s1_det_reg, s1_key_reg, s1_ok_reg;
    uv_t        s1_adc_reg;

    jack_kind_t jack_state_reg, jack_state_next;
    logic [2:0] pressed_marks_reg, pressed_marks_next;
    result_t    out_reg;
    result_t    res;

    logic       s1_adv;
    logic       in_accept;
    uv_t        v;
    logic       hit_media, hit_volup, hit_voldown;
    logic       occupied;

    assign s1_adv    = s1_valid_reg && (!out_reg.valid || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            media_min_reg   <= RST_MEDIA_MIN;
            media_max_reg   <= RST_MEDIA_MAX;
            volup_min_reg   <= RST_VOLUP_MIN;
            volup_max_reg   <= RST_VOLUP_MAX;
            voldown_min_reg <= RST_VOLDOWN_MIN;
            voldown_max_reg <= RST_VOLDOWN_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MEDIA_MIN:   media_min_reg   <= cfg_data;
                REG_MEDIA_MAX:   media_max_reg   <= cfg_data;
                REG_VOLUP_MIN:   volup_min_reg   <= cfg_data;
                REG_VOLUP_MAX:   volup_max_reg   <= cfg_data;
                REG_VOLDOWN_MIN: voldown_min_reg <= cfg_data;
                REG_VOLDOWN_MAX: voldown_max_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg <= mode;
            s1_det_reg  <= detect_level;
            s1_key_reg  <= key_level;
            s1_adc_reg  <= adc_uv;
            s1_ok_reg   <= adc_ok;
        end
    end

    // event decode
    assign v           = s1_ok_reg ? s1_adc_reg : '0;
    assign hit_media   = (v >= media_min_reg) && (v <= media_max_reg);
    assign hit_volup   = (v >= volup_min_reg) && (v <= volup_max_reg);
    assign hit_voldown = (v >= voldown_min_reg) && (v <= voldown_max_reg);
    assign occupied    = (jack_state_reg != JACK_EMPTY);

    always_comb
    begin
        res                   = '0;
        res.event_kind        = EV_JACK;
        res.jack_kind         = JACK_EMPTY;
        res.key_id            = KEY_PLAY;
        jack_state_next       = jack_state_reg;
        pressed_marks_next    = pressed_marks_reg;
        if (!s1_mode_reg)
        begin
            if (s1_det_reg)
            begin
                if (occupied)
                begin
                    res.valid        = 1'b1;
                    res.mic_reported = (jack_state_reg == JACK_MIC);
                    jack_state_next  = JACK_EMPTY;
                end
            end
            else if (!occupied)
            begin
                res.valid             = 1'b1;
                res.headphone_present = 1'b1;
                if (s1_key_reg)
                begin
                    res.jack_kind    = JACK_MIC;
                    res.mic_present  = 1'b1;
                    res.mic_reported = 1'b1;
                    jack_state_next  = JACK_MIC;
                end
                else
                begin
                    res.jack_kind    = JACK_HP;
                    jack_state_next  = JACK_HP;
                end
            end
        end
        else if (jack_state_reg == JACK_MIC && !s1_det_reg)
        begin
            if (!s1_key_reg)
            begin
                res.event_kind = EV_PRESS;
                res.key_down   = 1'b1;
                if (hit_media)
                begin
                    res.valid             = 1'b1;
                    res.key_id            = KEY_PLAY;
                    pressed_marks_next[0] = 1'b1;
                end
                else if (hit_volup)
                begin
                    res.valid             = 1'b1;
                    res.key_id            = KEY_VOLUP;
                    pressed_marks_next[1] = 1'b1;
                end
                else if (hit_voldown)
                begin
                    res.valid             = 1'b1;
                    res.key_id            = KEY_VOLDOWN;
                    pressed_marks_next[2] = 1'b1;
                end
            end
            else
            begin
                res.event_kind = EV_RELEASE;
                if (pressed_marks_reg[0])
                begin
                    res.valid             = 1'b1;
                    res.key_id            = KEY_PLAY;
                    pressed_marks_next[0] = 1'b0;
                end
                else if (pressed_marks_reg[1])
                begin
                    res.valid             = 1'b1;
                    res.key_id            = KEY_VOLUP;
                    pressed_marks_next[1] = 1'b0;
                end
                else if (pressed_marks_reg[2])
                begin
                    res.valid             = 1'b1;
                    res.key_id            = KEY_VOLDOWN;
                    pressed_marks_next[2] = 1'b0;
                end
            end
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jack_state_reg    <= JACK_EMPTY;
            pressed_marks_reg <= 3'b000;
            out_reg           <= '0;
        end
        else if (s1_adv)
        begin
            jack_state_reg    <= jack_state_next;
            pressed_marks_reg <= pressed_marks_next;
            out_reg           <= res;
        end
        else if (!out_stall)
        begin
            out_reg.valid     <= 1'b0;
        end
    end

    assign out_valid         = out_reg.valid;
    assign event_kind        = out_reg.event_kind;
    assign jack_kind         = out_reg.jack_kind;
    assign headphone_present = out_reg.headphone_present;
    assign mic_present       = out_reg.mic_present;
    assign mic_reported      = out_reg.mic_reported;
    assign key_id            = out_reg.key_id;
    assign key_down          = out_reg.key_down;

`ifndef NO_ASSERTIONS
    // key items only ever come out with a headset in
    a_key_needs_mic: assert property (@(posedge clk) disable iff (!rst_n)
        out_reg.valid && out_reg.event_kind != EV_JACK |-> jack_state_reg == JACK_MIC)
        else $error("key item without headset");

    a_press_marked: assert property (@(posedge clk) disable iff (!rst_n)
        out_reg.valid && out_reg.event_kind == EV_PRESS |->
            pressed_marks_reg[out_reg.key_id])
        else $error("pressed key not marked");

    a_release_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
        out_reg.valid && out_reg.event_kind == EV_RELEASE |->
            !pressed_marks_reg[out_reg.key_id])
        else $error("released key still marked");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> s1_valid_reg && $stable(s1_adc_reg) && $stable(s1_mode_reg))
        else $error("input register changed while stalled");
`endif

endmodule
